[hw/rtl/qrr_pkg.sv]
// Package with the sizes, status codes and pipeline types of the quadratic root solver.
`timescale 1ns / 1ps

package qrr_pkg;

   // Coefficient and result formats.
   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = 35;

   // Derived sizes of the discriminant, square root and divider.
   localparam int PROD_W  = 2 * COEF_WIDTH;
   localparam int DISC_W  = 2 * COEF_WIDTH + 3;
   localparam int DMAG_W  = 2 * COEF_WIDTH + 1;
   localparam int RAD_W   = DMAG_W + 2 * FRAC_BITS;
   localparam int SQ_N    = (RAD_W + 1) / 2;
   localparam int SQ_RADW = 2 * SQ_N;
   localparam int SQ_REMW = SQ_N + 2;
   localparam int NMAG_W  = ((COEF_WIDTH + FRAC_BITS > SQ_N) ?
                             (COEF_WIDTH + FRAC_BITS) : SQ_N) + 1;
   localparam int NS_W    = NMAG_W + 1;
   localparam int DEN_W   = COEF_WIDTH + 1;
   localparam int DV_REMW = DEN_W + 1;
   localparam int DV_N    = NMAG_W;
   localparam int QX_W    = (DV_N + 1 > OUT_W) ? (DV_N + 1) : OUT_W;

   // Number of real roots reported with each result.
   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_ONE   = 2'd1,
      ST_TWO   = 2'd2,
      ST_DEGEN = 2'd3
   } status_type;

   // Working state of one square root step.
   typedef struct packed {
      logic [SQ_REMW-1:0] rem;
      logic [SQ_N-1:0]    root;
      logic [SQ_RADW-1:0] rad;
   } sq_type;

   // Values carried alongside the square root.
   typedef struct packed {
      status_type                    status;
      logic signed [COEF_WIDTH-1:0]  a;
      logic signed [COEF_WIDTH-1:0]  b;
   } sq_side_type;

   // Working state of one divider step: partial remainder and dividend/quotient.
   typedef struct packed {
      logic [DV_REMW-1:0] rem;
      logic [DV_N-1:0]    nq;
   } dv_type;

   // Values carried alongside the dividers.
   typedef struct packed {
      status_type         status;
      logic [DEN_W-1:0]   den;
      logic               neg_p;
      logic               neg_m;
   } dv_side_type;

endpackage

[hw/rtl/quadratic_real_roots.sv]
// Pipelined solver for the real roots of a*x^2 + b*x + c in fixed point.
//
//   channel | ports                                        | direction
//   request | req_valid/req_ready, req_coef_a/b/c          | in
//   result  | rsp_valid/rsp_ready, rsp_root_status/plus/minus | out
//
// One request enters per cycle while the output register is free or being taken.
// The stages are the coefficient products, the discriminant, one square root step
// per root bit, the numerators, and one divider step per quotient bit.
// The whole pipeline holds while a result waits at the output; nothing is lost.
// Reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps

module quadratic_real_roots (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qrr_pkg::COEF_WIDTH-1:0]   req_coef_a,
   input  logic signed [qrr_pkg::COEF_WIDTH-1:0]   req_coef_b,
   input  logic signed [qrr_pkg::COEF_WIDTH-1:0]   req_coef_c,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output qrr_pkg::status_type                     rsp_root_status,
   output logic signed [qrr_pkg::OUT_W-1:0]        rsp_root_plus,
   output logic signed [qrr_pkg::OUT_W-1:0]        rsp_root_minus
);
   import qrr_pkg::*;

   // One restoring square root step: two radicand bits in, one root bit out.
   function automatic sq_type sq_step(sq_type x);
      logic [SQ_REMW-1:0] r;
      logic [SQ_REMW-1:0] t;
      sq_type             y;
      r = {x.rem[SQ_REMW-3:0], x.rad[SQ_RADW-1 -: 2]};
      t = {x.root, 2'b01};
      if (r >= t) begin
         y.rem  = r - t;
         y.root = {x.root[SQ_N-2:0], 1'b1};
      end else begin
         y.rem  = r;
         y.root = {x.root[SQ_N-2:0], 1'b0};
      end
      y.rad = {x.rad[SQ_RADW-3:0], 2'b00};
      return y;
   endfunction

   // One restoring division step: one dividend bit in, one quotient bit out.
   function automatic dv_type dv_step(dv_type x, logic [DEN_W-1:0] den);
      logic [DV_REMW-1:0] r;
      logic               q;
      dv_type             y;
      r = {x.rem[DV_REMW-2:0], x.nq[DV_N-1]};
      q = (r >= DV_REMW'(den));
      if (q) begin
         r = r - DV_REMW'(den);
      end
      y.rem = r;
      y.nq  = {x.nq[DV_N-2:0], q};
      return y;
   endfunction

   logic en;

   logic                          va_ff;
   logic signed [COEF_WIDTH-1:0]  a_ff, b_ff, c_ff;

   logic                          vb_ff;
   logic signed [PROD_W-1:0]      bb_in, ac_in, bb_ff, ac_ff;
   logic signed [COEF_WIDTH-1:0]  ab_ff, bb2_ff;

   logic                          vc_ff;
   logic signed [DISC_W-1:0]      disc_in;
   status_type                    stc_in, stc_ff;
   logic [DMAG_W-1:0]             dm_ff;
   logic signed [COEF_WIDTH-1:0]  ac2_ff, bc_ff;

   sq_type                        sq_entry;
   sq_type                        sq_d_in  [SQ_N];
   sq_type                        sq_d_ff  [SQ_N];
   sq_side_type                   sq_s_ff  [SQ_N];
   logic                          sq_v_ff  [SQ_N];

   logic signed [NS_W-1:0]        nb, s_ext, num_p, num_m;
   logic [COEF_WIDTH-1:0]         amag;
   logic                          vn_ff;
   dv_type                        dvp_n_in, dvm_n_in, dvp_n_ff, dvm_n_ff;
   dv_side_type                   dvs_n_in, dvs_n_ff;

   dv_type                        dvp_in [DV_N];
   dv_type                        dvm_in [DV_N];
   dv_type                        dvp_ff [DV_N];
   dv_type                        dvm_ff [DV_N];
   dv_side_type                   dvs_ff [DV_N];
   logic                          dv_v_ff[DV_N];

   logic signed [QX_W-1:0]        qp, qm;
   logic signed [OUT_W-1:0]       rp_in, rm_in;

   // The pipeline advances whenever the output register is free or being taken.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Coefficient products.
   assign bb_in = b_ff * b_ff;
   assign ac_in = a_ff * c_ff;

   // Discriminant and root count.
   always_comb begin
      disc_in = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      if (ab_ff == '0) begin
         stc_in = ST_DEGEN;
      end else if (disc_in < 0) begin
         stc_in = ST_NONE;
      end else if (disc_in == 0) begin
         stc_in = ST_ONE;
      end else begin
         stc_in = ST_TWO;
      end
   end

   // Square root steps, the radicand scaled by the fraction bits.
   always_comb begin
      sq_entry.rem  = '0;
      sq_entry.root = '0;
      sq_entry.rad  = SQ_RADW'(dm_ff) << (2 * FRAC_BITS);
      sq_d_in[0]    = sq_step(sq_entry);
      for (int k = 1; k < SQ_N; k++) begin
         sq_d_in[k] = sq_step(sq_d_ff[k-1]);
      end
   end

   // Signed numerators and divisor magnitude.
   always_comb begin
      nb    = -(NS_W'(sq_s_ff[SQ_N-1].b) <<< FRAC_BITS);
      s_ext = $signed(NS_W'(sq_d_ff[SQ_N-1].root));
      num_p = nb + s_ext;
      num_m = nb - s_ext;
      amag  = sq_s_ff[SQ_N-1].a[COEF_WIDTH-1] ? COEF_WIDTH'(-sq_s_ff[SQ_N-1].a)
                                               : COEF_WIDTH'(sq_s_ff[SQ_N-1].a);
      dvp_n_in.rem = '0;
      dvp_n_in.nq  = NMAG_W'(num_p[NS_W-1] ? -num_p : num_p);
      dvm_n_in.rem = '0;
      dvm_n_in.nq  = NMAG_W'(num_m[NS_W-1] ? -num_m : num_m);
      dvs_n_in.status = sq_s_ff[SQ_N-1].status;
      dvs_n_in.den    = {amag, 1'b0};
      dvs_n_in.neg_p  = num_p[NS_W-1] ^ sq_s_ff[SQ_N-1].a[COEF_WIDTH-1];
      dvs_n_in.neg_m  = num_m[NS_W-1] ^ sq_s_ff[SQ_N-1].a[COEF_WIDTH-1];
   end

   // Division steps for both roots side by side.
   always_comb begin
      dvp_in[0] = dv_step(dvp_n_ff, dvs_n_ff.den);
      dvm_in[0] = dv_step(dvm_n_ff, dvs_n_ff.den);
      for (int k = 1; k < DV_N; k++) begin
         dvp_in[k] = dv_step(dvp_ff[k-1], dvs_ff[k-1].den);
         dvm_in[k] = dv_step(dvm_ff[k-1], dvs_ff[k-1].den);
      end
   end

   // Signs applied, quotients truncated toward zero, unused roots cleared.
   always_comb begin
      qp = $signed(QX_W'(dvp_ff[DV_N-1].nq));
      qm = $signed(QX_W'(dvm_ff[DV_N-1].nq));
      if (dvs_ff[DV_N-1].neg_p) begin
         qp = -qp;
      end
      if (dvs_ff[DV_N-1].neg_m) begin
         qm = -qm;
      end
      rp_in = '0;
      rm_in = '0;
      if (dvs_ff[DV_N-1].status == ST_ONE || dvs_ff[DV_N-1].status == ST_TWO) begin
         rp_in = qp[OUT_W-1:0];
      end
      if (dvs_ff[DV_N-1].status == ST_TWO) begin
         rm_in = qm[OUT_W-1:0];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         vc_ff     <= 1'b0;
         vn_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         for (int k = 0; k < SQ_N; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k < DV_N; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         va_ff      <= req_valid;
         vb_ff      <= va_ff;
         vc_ff      <= vb_ff;
         sq_v_ff[0] <= vc_ff;
         for (int k = 1; k < SQ_N; k++) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
         vn_ff      <= sq_v_ff[SQ_N-1];
         dv_v_ff[0] <= vn_ff;
         for (int k = 1; k < DV_N; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
         rsp_valid  <= dv_v_ff[DV_N-1];
      end
   end

   // Pipeline data registers.
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= req_coef_a;
         b_ff   <= req_coef_b;
         c_ff   <= req_coef_c;
         bb_ff  <= bb_in;
         ac_ff  <= ac_in;
         ab_ff  <= a_ff;
         bb2_ff <= b_ff;
         stc_ff <= stc_in;
         dm_ff  <= (stc_in == ST_TWO) ? DMAG_W'(disc_in) : '0;
         ac2_ff <= ab_ff;
         bc_ff  <= bb2_ff;
         sq_s_ff[0].status <= stc_ff;
         sq_s_ff[0].a      <= ac2_ff;
         sq_s_ff[0].b      <= bc_ff;
         for (int k = 0; k < SQ_N; k++) begin
            sq_d_ff[k] <= sq_d_in[k];
         end
         for (int k = 1; k < SQ_N; k++) begin
            sq_s_ff[k] <= sq_s_ff[k-1];
         end
         dvp_n_ff <= dvp_n_in;
         dvm_n_ff <= dvm_n_in;
         dvs_n_ff <= dvs_n_in;
         dvs_ff[0] <= dvs_n_ff;
         for (int k = 0; k < DV_N; k++) begin
            dvp_ff[k] <= dvp_in[k];
            dvm_ff[k] <= dvm_in[k];
         end
         for (int k = 1; k < DV_N; k++) begin
            dvs_ff[k] <= dvs_ff[k-1];
         end
         rsp_root_status <= dvs_ff[DV_N-1].status;
         rsp_root_plus   <= rp_in;
         rsp_root_minus  <= rm_in;
      end
   end

endmodule
